// ===== sv/rss_pkg.sv =====
// Package for the record stack sorter: request/result structs, codes, sizes.
// No dependencies.
package rss_pkg;
	localparam int DEFAULT_DEPTH = 16;
	localparam int REC_W = 3 * (64 + 64 + 32) + 8;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP = 2'd1;
	localparam logic [1:0] REQ_SORT_NAME = 2'd2;
	localparam logic [1:0] REQ_SORT_AGE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY_POP = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [63:0] name_head;
		logic [63:0] name_middle;
		logic [31:0] name_tail;
		logic [63:0] surname_head;
		logic [63:0] surname_middle;
		logic [31:0] surname_tail;
		logic [63:0] work_head;
		logic [63:0] work_middle;
		logic [31:0] work_tail;
		logic [7:0] age_value;
	} req_t;

	typedef struct packed {
		logic [63:0] out_name_head;
		logic [63:0] out_name_middle;
		logic [31:0] out_name_tail;
		logic [63:0] out_surname_head;
		logic [63:0] out_surname_middle;
		logic [31:0] out_surname_tail;
		logic [63:0] out_work_head;
		logic [63:0] out_work_middle;
		logic [31:0] out_work_tail;
		logic [7:0] out_age;
		logic [1:0] status;
		logic last_entry;
	} rsp_t;
endpackage

// ===== sv/record_stack_sorter_core.sv =====
// Record stack sorter: push, pop and bubble sort over a record memory, then listing.
// Uses rss_pkg and rss_cmp.
//
// One request at a time. A push or pop updates the stack in the accept cycle; the
// first result passes through S_LWAIT and S_LRD before it is valid, and each further
// result goes through the same states after the previous one is taken (one per entry,
// one if empty), each held until taken. A sort runs compare-swap steps, each a read
// state and a compare state, through the shared comparator, in passes of count-1 steps
// until a pass makes no swap, before the listing starts.
module record_stack_sorter_core import rss_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rsp_t out_data
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_LRD = 3'd3;
	localparam logic [2:0] S_LOUT = 3'd4;
	localparam logic [2:0] S_LWAIT = 3'd5;

	logic [REC_W-1:0] mem [STACK_DEPTH];
	logic [2:0] state_q;
	logic [CW-1:0] count_q, idx_q;
	logic [1:0] status_q;
	logic by_age_q, swapped_q;
	logic [REC_W-1:0] ra_q, rb_q;
	logic greater;
	rsp_t out_q;
	logic out_valid_q;

	rss_cmp u_cmp (.a(ra_q), .b(rb_q), .by_age(by_age_q), .greater(greater));

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// memory: two read ports (idx, idx-1), registered; a push writes one entry, a swap writes two
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_data.req_type == REQ_PUSH &&
				count_q < CW'(STACK_DEPTH))
			mem[count_q[AW-1:0]] <= in_data[REC_W-1+2-2:0];
		else if (state_q == S_CMP && greater) begin
			mem[idx_q[AW-1:0]] <= rb_q;
			mem[AW'(idx_q - 1'b1)] <= ra_q;
		end
		ra_q <= mem[idx_q[AW-1:0]];
		rb_q <= mem[AW'(idx_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			status_q <= ST_OK;
			by_age_q <= 1'b0;
			swapped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						by_age_q <= in_data.req_type == REQ_SORT_AGE;
						swapped_q <= 1'b0;
						case (in_data.req_type)
							REQ_PUSH: begin
								state_q <= S_LWAIT;
								if (count_q < CW'(STACK_DEPTH)) begin
									status_q <= ST_OK;
									count_q <= count_q + 1'b1;
									idx_q <= count_q;
								end else begin
									status_q <= ST_FULL;
									idx_q <= count_q - 1'b1;
								end
							end
							REQ_POP: begin
								state_q <= S_LWAIT;
								if (count_q == '0) begin
									status_q <= ST_EMPTY_POP;
									idx_q <= count_q - 1'b1;
								end else begin
									status_q <= ST_OK;
									count_q <= count_q - 1'b1;
									idx_q <= count_q - CW'(2);
								end
							end
							default: begin
								status_q <= ST_OK;
								idx_q <= count_q - 1'b1;
								state_q <= (count_q >= CW'(2)) ? S_READ : S_LWAIT;
							end
						endcase
					end
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (idx_q == CW'(1)) begin
						if (swapped_q || greater) begin
							swapped_q <= 1'b0;
							idx_q <= count_q - 1'b1;
							state_q <= S_READ;
						end else begin
							idx_q <= count_q - 1'b1;
							state_q <= S_LWAIT;
						end
					end else begin
						swapped_q <= swapped_q | greater;
						idx_q <= idx_q - 1'b1;
						state_q <= S_READ;
					end
				end
				// wait for the entry at idx to reach ra_q
				S_LWAIT: state_q <= S_LRD;
				S_LRD: begin
					// ra_q now holds the entry at idx
					out_valid_q <= 1'b1;
					state_q <= S_LOUT;
					if (count_q == '0)
						out_q <= {{REC_W{1'b0}},
							(status_q != ST_OK) ? status_q : ST_EMPTY, 1'b1};
					else
						out_q <= {ra_q, status_q, idx_q == '0};
				end
				S_LOUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_q.last_entry)
							state_q <= S_IDLE;
						else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_LWAIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH)) else $error("entry count overflow");
	a_out_only_listing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_LOUT) else $error("result outside listing");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken during listing");
`endif
endmodule

// ===== sv/rss_cmp.sv =====
// Shared key comparator: a > b on 20-byte name (C string order) or age.
// Depends on rss_pkg.
module rss_cmp import rss_pkg::*; (
	input logic [REC_W-1:0] a,
	input logic [REC_W-1:0] b,
	input logic by_age,
	output logic greater
);
	logic [159:0] na, nb;
	logic gt, done;
	always_comb begin
		na = a[REC_W-1 -: 160];
		nb = b[REC_W-1 -: 160];
		gt = 1'b0;
		done = 1'b0;
		for (int k = 0; k < 20; k++) begin
			if (!done) begin
				if (na[159-8*k -: 8] != nb[159-8*k -: 8]) begin
					gt = na[159-8*k -: 8] > nb[159-8*k -: 8];
					done = 1'b1;
				end else if (na[159-8*k -: 8] == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		greater = by_age ? (a[7:0] > b[7:0]) : gt;
	end
endmodule
